### rtl/gprs_pkg.sv
`timescale 1ns / 1ps
package gprs_pkg;

    localparam int GRID_MAX = 64;
    localparam int COORD_W  = 7;
    localparam int AMT_W    = 32;
    localparam int SUM_W    = 64;

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_ADD_RD,
        S_ADD_WR,
        S_Q_VISIT,
        S_Q_ACC,
        S_Q_CHILD
    } t_state;

    // Number of quadtree node slots, slot 0 unused, root at slot 1.
    function automatic int node_count(input int gmax);
        int lg;
        lg = $clog2(gmax);
        return ((1 << (2 * (lg + 1))) - 1) / 3 + 1;
    endfunction

endpackage

### rtl/gprs_ram.sv
`timescale 1ns / 1ps
module gprs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/grid_point_add_rect_sum.sv
`timescale 1ns / 1ps
// An add walks root to leaf through S_ADD_RD and S_ADD_WR at each tree level.
// A query walks the node tree depth first through a register stack: S_Q_VISIT for each node
// visited, S_Q_CHILD for the four child tests of a split node and to close it; a covered
// node adds S_Q_ACC for the memory read; a query with an empty rectangle returns zero
// without a walk. The result strobe is registered; no stall. Reset and every grid_size
// write start a pass that zeroes every node slot (5462 at GRID_MAX of 64); busy is high.
module grid_point_add_rect_sum #(
    parameter int GRID_MAX = gprs_pkg::GRID_MAX
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 i_op,
    input  logic [gprs_pkg::COORD_W-1:0]         i_row_a,
    input  logic [gprs_pkg::COORD_W-1:0]         i_col_a,
    input  logic [gprs_pkg::COORD_W-1:0]         i_row_b,
    input  logic [gprs_pkg::COORD_W-1:0]         i_col_b,
    input  logic signed [gprs_pkg::AMT_W-1:0]    i_amount,
    output logic                                 o_valid,
    output logic signed [gprs_pkg::SUM_W-1:0]    o_rect_sum,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [gprs_pkg::COORD_W-1:0]         i_cfg_data
);

    localparam int NODES = gprs_pkg::node_count(GRID_MAX);
    localparam int AW    = $clog2(NODES);
    localparam int NW    = AW + 2;
    localparam int DEPTH = $clog2(GRID_MAX) + 1;
    localparam int SW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = gprs_pkg::COORD_W;
    localparam int DW    = gprs_pkg::SUM_W;
    localparam int AMW   = gprs_pkg::AMT_W;

    gprs_pkg::t_state r_state, n_state;

    logic [CW-1:0] r_grid, n_grid;
    logic [AW-1:0] r_clr, n_clr;
    logic [NW-1:0] r_node, n_node;
    logic [CW-1:0] r_xl, r_xr, r_yl, r_yr, n_xl, n_xr, n_yl, n_yr;
    logic [CW-1:0] r_px, r_py, n_px, n_py;
    logic [CW-1:0] r_qxl, r_qyl, r_qxr, r_qyr, n_qxl, n_qyl, n_qxr, n_qyr;
    logic [DW-1:0] r_amt, n_amt;
    logic [DW-1:0] r_acc, n_acc;
    logic [SW-1:0] r_sp, n_sp;
    logic [AW-1:0] r_stk_node [DEPTH];
    logic [AW-1:0] n_stk_node [DEPTH];
    logic [CW-1:0] r_stk_xl [DEPTH];
    logic [CW-1:0] n_stk_xl [DEPTH];
    logic [CW-1:0] r_stk_xr [DEPTH];
    logic [CW-1:0] n_stk_xr [DEPTH];
    logic [CW-1:0] r_stk_yl [DEPTH];
    logic [CW-1:0] n_stk_yl [DEPTH];
    logic [CW-1:0] r_stk_yr [DEPTH];
    logic [CW-1:0] n_stk_yr [DEPTH];
    logic [2:0]    r_stk_ch [DEPTH];
    logic [2:0]    n_stk_ch [DEPTH];
    logic          r_out_valid, n_out_valid;
    logic [DW-1:0] r_out_sum, n_out_sum;

    logic          w_cfg_wr, w_start;
    logic [CW-1:0] w_n, w_qxl, w_qyl, w_qxr, w_qyr, w_px, w_py;
    logic          w_q_ok, w_fit, w_empty, w_cover, w_leaf, w_sp_zero;
    logic [CW-1:0] w_mx, w_my;
    logic [AW-1:0] w_t_node;
    logic [CW-1:0] w_t_xl, w_t_xr, w_t_yl, w_t_yr, w_tmx, w_tmy;
    logic [2:0]    w_t_ch;
    logic          w_ch_end, w_ch_ok;
    logic [NW-1:0] w_add_child, w_q_child;

    logic          w_we, w_re;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [DW-1:0] w_wdata, w_rdata;

    gprs_ram #(
        .WIDTH(DW),
        .DEPTH(NODES)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_re   (w_re),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid;
    assign busy        = (r_state != gprs_pkg::S_IDLE);
    assign w_start     = start && !busy;
    assign o_valid     = r_out_valid;
    assign o_rect_sum  = r_out_sum;

    always_comb begin
        if (r_grid == '0) begin
            w_n = CW'(1);
        end else if (int'(r_grid) > GRID_MAX) begin
            w_n = CW'(GRID_MAX);
        end else begin
            w_n = r_grid;
        end
    end

    assign w_qxl  = (i_row_a == '0) ? CW'(1) : i_row_a;
    assign w_qyl  = (i_col_a == '0) ? CW'(1) : i_col_a;
    assign w_qxr  = (i_row_b > w_n) ? w_n : i_row_b;
    assign w_qyr  = (i_col_b > w_n) ? w_n : i_col_b;
    assign w_q_ok = (w_qxl <= w_qxr) && (w_qyl <= w_qyr);
    assign w_px   = (i_row_a == '0) ? CW'(1) : ((i_row_a > w_n) ? w_n : i_row_a);
    assign w_py   = (i_col_a == '0) ? CW'(1) : ((i_col_a > w_n) ? w_n : i_col_a);

    assign w_fit     = (r_node < NW'(NODES));
    assign w_empty   = (r_xl > r_xr) || (r_yl > r_yr) || !w_fit;
    assign w_cover   = (r_qxl <= r_xl) && (r_xr <= r_qxr) && (r_qyl <= r_yl) && (r_yr <= r_qyr);
    assign w_leaf    = (r_xl == r_xr) && (r_yl == r_yr);
    assign w_sp_zero = (r_sp == '0);

    assign w_mx = CW'(({1'b0, r_xl} + {1'b0, r_xr}) >> 1);
    assign w_my = CW'(({1'b0, r_yl} + {1'b0, r_yr}) >> 1);
    assign w_add_child = NW'(r_node << 2) - NW'(2)
                       + NW'({(r_px > w_mx), (r_py > w_my)});

    assign w_t_node = r_stk_node[r_sp];
    assign w_t_xl   = r_stk_xl[r_sp];
    assign w_t_xr   = r_stk_xr[r_sp];
    assign w_t_yl   = r_stk_yl[r_sp];
    assign w_t_yr   = r_stk_yr[r_sp];
    assign w_t_ch   = r_stk_ch[r_sp];
    assign w_tmx    = CW'(({1'b0, w_t_xl} + {1'b0, w_t_xr}) >> 1);
    assign w_tmy    = CW'(({1'b0, w_t_yl} + {1'b0, w_t_yr}) >> 1);
    assign w_ch_end = w_t_ch[2];
    assign w_q_child = NW'({2'b00, w_t_node} << 2) - NW'(2) + NW'(w_t_ch[1:0]);

    always_comb begin
        case (w_t_ch[1:0])
            2'd0:    w_ch_ok = (r_qxl <= w_tmx) && (r_qyl <= w_tmy);
            2'd1:    w_ch_ok = (r_qxl <= w_tmx) && (r_qyr > w_tmy);
            2'd2:    w_ch_ok = (r_qxr > w_tmx) && (r_qyl <= w_tmy);
            default: w_ch_ok = (r_qxr > w_tmx) && (r_qyr > w_tmy);
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            gprs_pkg::S_CLR: begin
                if (r_clr == AW'(NODES - 1)) begin
                    n_state = gprs_pkg::S_IDLE;
                end
            end
            gprs_pkg::S_IDLE: begin
                if (w_start) begin
                    if (i_op == gprs_pkg::OP_ADD) begin
                        n_state = gprs_pkg::S_ADD_RD;
                    end else if (w_q_ok) begin
                        n_state = gprs_pkg::S_Q_VISIT;
                    end
                end
            end
            gprs_pkg::S_ADD_RD: begin
                n_state = w_fit ? gprs_pkg::S_ADD_WR : gprs_pkg::S_IDLE;
            end
            gprs_pkg::S_ADD_WR: begin
                n_state = w_leaf ? gprs_pkg::S_IDLE : gprs_pkg::S_ADD_RD;
            end
            gprs_pkg::S_Q_VISIT: begin
                if (w_empty || (!w_cover && w_leaf)) begin
                    n_state = w_sp_zero ? gprs_pkg::S_IDLE : gprs_pkg::S_Q_CHILD;
                end else if (w_cover) begin
                    n_state = gprs_pkg::S_Q_ACC;
                end else begin
                    n_state = gprs_pkg::S_Q_CHILD;
                end
            end
            gprs_pkg::S_Q_ACC: begin
                n_state = w_sp_zero ? gprs_pkg::S_IDLE : gprs_pkg::S_Q_CHILD;
            end
            gprs_pkg::S_Q_CHILD: begin
                if (w_ch_end) begin
                    n_state = w_sp_zero ? gprs_pkg::S_IDLE : gprs_pkg::S_Q_CHILD;
                end else if (w_ch_ok) begin
                    n_state = gprs_pkg::S_Q_VISIT;
                end
            end
            default: n_state = gprs_pkg::S_CLR;
        endcase
        if (w_cfg_wr) begin
            n_state = gprs_pkg::S_CLR;
        end
    end

    always_comb begin
        n_grid      = r_grid;
        n_clr       = r_clr;
        n_node      = r_node;
        n_xl        = r_xl;
        n_xr        = r_xr;
        n_yl        = r_yl;
        n_yr        = r_yr;
        n_px        = r_px;
        n_py        = r_py;
        n_qxl       = r_qxl;
        n_qyl       = r_qyl;
        n_qxr       = r_qxr;
        n_qyr       = r_qyr;
        n_amt       = r_amt;
        n_acc       = r_acc;
        n_sp        = r_sp;
        n_stk_node  = r_stk_node;
        n_stk_xl    = r_stk_xl;
        n_stk_xr    = r_stk_xr;
        n_stk_yl    = r_stk_yl;
        n_stk_yr    = r_stk_yr;
        n_stk_ch    = r_stk_ch;
        n_out_valid = 1'b0;
        n_out_sum   = r_out_sum;
        w_we        = 1'b0;
        w_waddr     = r_node[AW-1:0];
        w_wdata     = r_acc;
        w_re        = 1'b0;
        w_raddr     = r_node[AW-1:0];
        case (r_state)
            gprs_pkg::S_CLR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                w_wdata = '0;
                n_clr   = r_clr + AW'(1);
            end
            gprs_pkg::S_IDLE: begin
                if (w_start) begin
                    n_node = NW'(1);
                    n_xl   = CW'(1);
                    n_xr   = w_n;
                    n_yl   = CW'(1);
                    n_yr   = w_n;
                    n_px   = w_px;
                    n_py   = w_py;
                    n_amt  = {{(DW - AMW){i_amount[AMW-1]}}, i_amount};
                    n_qxl  = w_qxl;
                    n_qyl  = w_qyl;
                    n_qxr  = w_qxr;
                    n_qyr  = w_qyr;
                    n_acc  = '0;
                    n_sp   = '0;
                    if ((i_op == gprs_pkg::OP_QUERY) && !w_q_ok) begin
                        n_out_valid = 1'b1;
                        n_out_sum   = '0;
                    end
                end
            end
            gprs_pkg::S_ADD_RD: begin
                w_re = w_fit;
            end
            gprs_pkg::S_ADD_WR: begin
                w_we    = 1'b1;
                w_wdata = w_rdata + r_amt;
                n_node  = w_add_child;
                if (r_px > w_mx) begin
                    n_xl = CW'(w_mx + CW'(1));
                end else begin
                    n_xr = w_mx;
                end
                if (r_py > w_my) begin
                    n_yl = CW'(w_my + CW'(1));
                end else begin
                    n_yr = w_my;
                end
            end
            gprs_pkg::S_Q_VISIT: begin
                if (w_empty || (!w_cover && w_leaf)) begin
                    if (w_sp_zero) begin
                        n_out_valid = 1'b1;
                        n_out_sum   = r_acc;
                    end else begin
                        n_sp = r_sp - SW'(1);
                    end
                end else if (w_cover) begin
                    w_re = 1'b1;
                end else begin
                    n_stk_node[r_sp] = r_node[AW-1:0];
                    n_stk_xl[r_sp]   = r_xl;
                    n_stk_xr[r_sp]   = r_xr;
                    n_stk_yl[r_sp]   = r_yl;
                    n_stk_yr[r_sp]   = r_yr;
                    n_stk_ch[r_sp]   = 3'd0;
                end
            end
            gprs_pkg::S_Q_ACC: begin
                n_acc = r_acc + w_rdata;
                if (w_sp_zero) begin
                    n_out_valid = 1'b1;
                    n_out_sum   = r_acc + w_rdata;
                end else begin
                    n_sp = r_sp - SW'(1);
                end
            end
            gprs_pkg::S_Q_CHILD: begin
                if (w_ch_end) begin
                    if (w_sp_zero) begin
                        n_out_valid = 1'b1;
                        n_out_sum   = r_acc;
                    end else begin
                        n_sp = r_sp - SW'(1);
                    end
                end else begin
                    n_stk_ch[r_sp] = w_t_ch + 3'd1;
                    if (w_ch_ok) begin
                        n_node = w_q_child;
                        n_sp   = r_sp + SW'(1);
                        if (w_t_ch[1]) begin
                            n_xl = CW'(w_tmx + CW'(1));
                            n_xr = w_t_xr;
                        end else begin
                            n_xl = w_t_xl;
                            n_xr = w_tmx;
                        end
                        if (w_t_ch[0]) begin
                            n_yl = CW'(w_tmy + CW'(1));
                            n_yr = w_t_yr;
                        end else begin
                            n_yl = w_t_yl;
                            n_yr = w_tmy;
                        end
                    end
                end
            end
            default: begin
                n_clr = '0;
            end
        endcase
        if (w_cfg_wr) begin
            n_grid = i_cfg_data;
            n_clr  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gprs_pkg::S_CLR;
            r_grid      <= CW'(64);
            r_clr       <= '0;
            r_sp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_grid      <= n_grid;
            r_clr       <= n_clr;
            r_sp        <= n_sp;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_node     <= n_node;
        r_xl       <= n_xl;
        r_xr       <= n_xr;
        r_yl       <= n_yl;
        r_yr       <= n_yr;
        r_px       <= n_px;
        r_py       <= n_py;
        r_qxl      <= n_qxl;
        r_qyl      <= n_qyl;
        r_qxr      <= n_qxr;
        r_qyr      <= n_qyr;
        r_amt      <= n_amt;
        r_acc      <= n_acc;
        r_stk_node <= n_stk_node;
        r_stk_xl   <= n_stk_xl;
        r_stk_xr   <= n_stk_xr;
        r_stk_yl   <= n_stk_yl;
        r_stk_yr   <= n_stk_yr;
        r_stk_ch   <= n_stk_ch;
        r_out_sum  <= n_out_sum;
    end

    a_valid_from_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(r_state) == gprs_pkg::S_Q_VISIT || $past(r_state) == gprs_pkg::S_Q_ACC
            || $past(r_state) == gprs_pkg::S_Q_CHILD
            || ($past(r_state) == gprs_pkg::S_IDLE && $past(start) && $past(i_op))))
        else $error("result strobe without a query transaction");

    a_no_write_in_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gprs_pkg::S_Q_VISIT || r_state == gprs_pkg::S_Q_ACC
            || r_state == gprs_pkg::S_Q_CHILD) |-> !w_we)
        else $error("node memory written during a query");

    a_cfg_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |=> (r_state == gprs_pkg::S_CLR && r_clr == '0))
        else $error("grid size write did not restart the clearing pass");

endmodule

### test/tb_grid_point_add_rect_sum.sv
`timescale 1ns / 1ps
module tb_grid_point_add_rect_sum;

    typedef struct {
        logic                              op;
        logic [gprs_pkg::COORD_W-1:0]      row_a;
        logic [gprs_pkg::COORD_W-1:0]      col_a;
        logic [gprs_pkg::COORD_W-1:0]      row_b;
        logic [gprs_pkg::COORD_W-1:0]      col_b;
        logic signed [gprs_pkg::AMT_W-1:0] amount;
    } t_cmd;

    localparam int CYCLE_LIMIT = 20000000;
    localparam int DRAIN_CYCLES = 300;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              start;
    logic                              busy;
    logic                              i_op;
    logic [gprs_pkg::COORD_W-1:0]      i_row_a;
    logic [gprs_pkg::COORD_W-1:0]      i_col_a;
    logic [gprs_pkg::COORD_W-1:0]      i_row_b;
    logic [gprs_pkg::COORD_W-1:0]      i_col_b;
    logic signed [gprs_pkg::AMT_W-1:0] i_amount;
    logic                              o_valid;
    logic signed [gprs_pkg::SUM_W-1:0] o_rect_sum;
    logic                              i_cfg_valid;
    logic                              o_cfg_ready;
    logic [gprs_pkg::COORD_W-1:0]      i_cfg_data;

    t_cmd                          pending_cmds[$];
    logic [gprs_pkg::SUM_W-1:0]    expected_sums[$];
    logic [gprs_pkg::SUM_W-1:0]    cell_vals[1:gprs_pkg::GRID_MAX][1:gprs_pkg::GRID_MAX];
    int                            side;
    int                            fails = 0;
    int                            cycles = 0;
    int                            gap_left = 0;
    bit                            no_idle = 0;
    bit                            cmd_taken = 0;

    grid_point_add_rect_sum dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_op        (i_op),
        .i_row_a     (i_row_a),
        .i_col_a     (i_col_a),
        .i_row_b     (i_row_b),
        .i_col_b     (i_col_b),
        .i_amount    (i_amount),
        .o_valid     (o_valid),
        .o_rect_sum  (o_rect_sum),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic void clear_grid(input logic [gprs_pkg::COORD_W-1:0] size_reg);
        for (int r = 1; r <= gprs_pkg::GRID_MAX; r++)
            for (int c = 1; c <= gprs_pkg::GRID_MAX; c++)
                cell_vals[r][c] = '0;
        side = (size_reg == 0) ? 1 :
               ((size_reg > gprs_pkg::GRID_MAX) ? gprs_pkg::GRID_MAX : int'(size_reg));
    endfunction

    function automatic int clamp_coord(input int v);
        if (v < 1) return 1;
        if (v > side) return side;
        return v;
    endfunction

    function automatic logic [gprs_pkg::SUM_W-1:0] rect_total(input t_cmd cmd);
        int top, left, bottom, right;
        logic [gprs_pkg::SUM_W-1:0] acc;
        top    = (cmd.row_a < 1) ? 1 : int'(cmd.row_a);
        left   = (cmd.col_a < 1) ? 1 : int'(cmd.col_a);
        bottom = (cmd.row_b > side) ? side : int'(cmd.row_b);
        right  = (cmd.col_b > side) ? side : int'(cmd.col_b);
        acc = '0;
        for (int r = top; r <= bottom; r++)
            for (int c = left; c <= right; c++)
                acc += cell_vals[r][c];
        return acc;
    endfunction

    function automatic void apply_cmd(input t_cmd cmd);
        int r, c;
        if (cmd.op == gprs_pkg::OP_ADD) begin
            r = clamp_coord(int'(cmd.row_a));
            c = clamp_coord(int'(cmd.col_a));
            cell_vals[r][c] += {{(gprs_pkg::SUM_W-gprs_pkg::AMT_W){
                                   cmd.amount[gprs_pkg::AMT_W-1]}}, cmd.amount};
        end else begin
            expected_sums.push_back(rect_total(cmd));
        end
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
        if (i_rst_n) begin
            if (o_valid) begin
                if (expected_sums.size() == 0) begin
                    $error("rect_sum: unexpected result %0d", o_rect_sum);
                    fails++;
                end else begin
                    if (o_rect_sum !== expected_sums[0]) begin
                        $error("rect_sum: expected %0d, got %0d",
                               $signed(expected_sums[0]), o_rect_sum);
                        fails++;
                    end
                    void'(expected_sums.pop_front());
                end
            end
            cmd_taken = start && !busy;
            if (cmd_taken)
                apply_cmd('{i_op, i_row_a, i_col_a, i_row_b, i_col_b, i_amount});
            if (i_cfg_valid && o_cfg_ready)
                clear_grid(i_cfg_data);
        end
    end

    always @(negedge i_clk) begin
        t_cmd cmd;
        logic next_start;
        next_start = start;
        if (i_rst_n && !(start && !cmd_taken)) begin
            next_start = 1'b0;
            if (start)
                gap_left = no_idle ? 0 : $urandom_range(0, 17);
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_cmds.size() > 0) begin
                cmd = pending_cmds.pop_front();
                i_op     <= cmd.op;
                i_row_a  <= cmd.row_a;
                i_col_a  <= cmd.col_a;
                i_row_b  <= cmd.row_b;
                i_col_b  <= cmd.col_b;
                i_amount <= cmd.amount;
                next_start = 1'b1;
            end
        end
        start <= next_start;
    end

    task automatic queue_cmd(input logic op, input int ra, input int ca, input int rb,
                             input int cb, input logic [gprs_pkg::AMT_W-1:0] amt);
        t_cmd cmd;
        cmd = '{op, ra[gprs_pkg::COORD_W-1:0], ca[gprs_pkg::COORD_W-1:0],
                rb[gprs_pkg::COORD_W-1:0], cb[gprs_pkg::COORD_W-1:0], amt};
        pending_cmds.push_back(cmd);
    endtask

    function automatic int pick_coord();
        if ($urandom_range(0, 9) == 0) return $urandom_range(0, 127);
        return $urandom_range(0, side + 1);
    endfunction

    task automatic queue_random(input int count);
        int a, b, c, d;
        logic [gprs_pkg::AMT_W-1:0] amt;
        for (int k = 0; k < count; k++) begin
            a = pick_coord();
            b = pick_coord();
            c = pick_coord();
            d = pick_coord();
            amt = $urandom();
            if ($urandom_range(0, 1)) begin
                queue_cmd(gprs_pkg::OP_ADD, a, b, c, d, amt);
            end else if ($urandom_range(0, 3) != 0) begin
                queue_cmd(gprs_pkg::OP_QUERY, (a < c) ? a : c, (b < d) ? b : d,
                          (a < c) ? c : a, (b < d) ? d : b, amt);
            end else begin
                queue_cmd(gprs_pkg::OP_QUERY, a, b, c, d, amt);
            end
        end
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (pending_cmds.size() != 0 || start || expected_sums.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_size(input logic [gprs_pkg::COORD_W-1:0] size_reg);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= size_reg;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [gprs_pkg::COORD_W-1:0] sizes[6];
        sizes = '{7'd1, 7'd0, 7'd127, 7'd2, 7'd37, 7'd64};
        start       = 1'b0;
        i_op        = gprs_pkg::OP_ADD;
        i_row_a     = '0;
        i_col_a     = '0;
        i_row_b     = '0;
        i_col_b     = '0;
        i_amount    = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        i_rst_n     = 1'b0;
        clear_grid(7'd64);
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        queue_cmd(gprs_pkg::OP_QUERY, 1, 1, 64, 64, 0);
        queue_cmd(gprs_pkg::OP_ADD, 1, 1, 0, 0, 32'h7FFF_FFFF);
        queue_cmd(gprs_pkg::OP_ADD, 64, 64, 127, 127, 32'h8000_0000);
        queue_cmd(gprs_pkg::OP_ADD, 0, 127, 0, 0, 32'hFFFF_FFFF);
        queue_cmd(gprs_pkg::OP_ADD, 127, 0, 0, 0, 32'd5);
        queue_cmd(gprs_pkg::OP_ADD, 33, 32, 0, 0, 32'h5555_5555);
        queue_cmd(gprs_pkg::OP_QUERY, 1, 1, 64, 64, 32'hFFFF_FFFF);
        queue_cmd(gprs_pkg::OP_QUERY, 0, 0, 127, 127, 0);
        queue_cmd(gprs_pkg::OP_QUERY, 1, 1, 1, 1, 0);
        queue_cmd(gprs_pkg::OP_QUERY, 64, 64, 64, 64, 0);
        queue_cmd(gprs_pkg::OP_QUERY, 1, 64, 1, 64, 0);
        queue_cmd(gprs_pkg::OP_QUERY, 64, 1, 64, 1, 0);
        queue_cmd(gprs_pkg::OP_QUERY, 10, 10, 9, 20, 0);
        queue_cmd(gprs_pkg::OP_QUERY, 10, 10, 20, 9, 0);
        queue_cmd(gprs_pkg::OP_QUERY, 65, 1, 127, 64, 0);
        queue_cmd(gprs_pkg::OP_QUERY, 32, 32, 33, 33, 0);
        queue_cmd(gprs_pkg::OP_QUERY, 2, 2, 63, 63, 0);
        for (int k = 0; k < 4; k++)
            queue_cmd(gprs_pkg::OP_ADD, 40, 40, 0, 0, 32'h7FFF_FFFF);
        queue_cmd(gprs_pkg::OP_QUERY, 40, 40, 40, 40, 0);
        queue_cmd(gprs_pkg::OP_QUERY, 1, 1, 127, 127, 0);
        queue_random(100);
        wait_idle();

        foreach (sizes[p]) begin
            write_size(sizes[p]);
            no_idle = (p % 2 == 1);
            queue_random(115);
            wait_idle();
        end

        if (fails == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
